/* hdl/hfd_pkg.sv */
package hfd_pkg;

    localparam int NODE_COUNT = 512;
    localparam int IDX_W      = 9;
    localparam int SYM_W      = 8;
    localparam int CODE_W     = 8;
    localparam int CNT_W      = 4;

    // s_tuser codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] right;
        logic [IDX_W-1:0] left;
    } node_t;

    // walker to output stage
    typedef struct packed {
        logic             push;
        logic             fin;
        logic [SYM_W-1:0] sym;
    } hfd_emit_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_STEP  = 4'b0100,
        S_FLUSH = 4'b1000
    } walk_state_t;

endpackage

/* hdl/hfd_code_shift.sv */
module hfd_code_shift
    import hfd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [CODE_W-1:0] load_byte,
    input  logic [CNT_W-1:0]  load_cnt,
    input  logic              shift,
    output logic              bit_msb,
    output logic              bits_empty
);

    logic [CODE_W-1:0] byte_reg, byte_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_comb begin
        byte_next = byte_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            byte_next = load_byte;
            // counts above the byte width saturate
            cnt_next  = (load_cnt > CNT_W'(CODE_W)) ? CNT_W'(CODE_W) : load_cnt;
        end else if (shift) begin
            byte_next = {byte_reg[CODE_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign bit_msb    = byte_reg[CODE_W-1];
    assign bits_empty = (cnt_reg == '0);

endmodule

/* hdl/hfd_walk.sv */
module hfd_walk
    import hfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic             in_nbits_zero,
    input  node_t            in_node,
    input  logic [IDX_W-1:0] in_node_index,
    input  logic             bit_msb,
    input  logic             bits_empty,
    output logic             bit_shift,
    output hfd_emit_t        emit,
    input  logic             emit_ready
);

    node_t            mem [NODE_COUNT];
    node_t            rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;

    walk_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic             chk_reg, chk_next;
    logic [IDX_W-1:0] child;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[in_node_index] <= in_node;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign in_ready = (state_reg == S_IDLE);
    assign child    = bit_msb ? rd_data_reg.right : rd_data_reg.left;

    always_comb begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        root_next   = root_reg;
        chk_next    = chk_reg;
        rd_addr     = cursor_reg;
        bit_shift   = 1'b0;
        wr_en       = 1'b0;
        emit        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    if (in_op == OP_WRITE) begin
                        wr_en = 1'b1;
                    end else if (!in_nbits_zero) begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                chk_next   = 1'b0;
                state_next = S_STEP;
            end
            S_STEP: begin
                // chk_reg: rd_data_reg is a node just entered, test for a leaf
                if (chk_reg && rd_data_reg.leaf) begin
                    emit.push = 1'b1;
                    emit.sym  = rd_data_reg.symbol;
                    if (emit_ready) begin
                        cursor_next = root_reg;
                        rd_addr     = root_reg;
                        chk_next    = 1'b0;
                    end
                end else if (bits_empty) begin
                    state_next = S_FLUSH;
                end else begin
                    rd_addr     = child;
                    cursor_next = child;
                    chk_next    = 1'b1;
                    bit_shift   = 1'b1;
                end
            end
            S_FLUSH: begin
                emit.fin = 1'b1;
                if (emit_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        // new root restarts the walk
        if (cfg_wr_en) begin
            root_next   = cfg_wr_data;
            cursor_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            root_reg   <= '0;
            chk_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            root_reg   <= root_next;
            chk_reg    <= chk_next;
        end
    end

`ifndef SYNTHESIS
    a_leaf_to_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.push && emit_ready) |=> (cursor_reg == root_reg))
        else $error("cursor not back at root after leaf");

    a_push_fin_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(emit.push && emit.fin))
        else $error("push and fin together");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.push && !emit_ready && !cfg_wr_en) |=> (emit.push && $stable(emit.sym)))
        else $error("stalled symbol changed");

    a_no_shift_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> (!bit_shift && !emit.push && !emit.fin))
        else $error("walk activity while idle");
`endif

endmodule

/* hdl/hfd_out_stage.sv */
module hfd_out_stage
    import hfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  hfd_emit_t        emit,
    output logic             emit_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_sym,
    output logic             m_last
);

    // one symbol held back until it is known whether another follows
    logic             pend_valid_reg, pend_valid_next;
    logic [SYM_W-1:0] pend_sym_reg, pend_sym_next;
    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] m_sym_reg, m_sym_next;
    logic             m_last_reg, m_last_next;

    assign emit_ready = !pend_valid_reg || !m_valid_reg || m_tready;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_sym_next      = m_sym_reg;
        m_last_next     = m_last_reg;
        if ((emit.push || emit.fin) && pend_valid_reg && emit_ready) begin
            m_valid_next = 1'b1;
            m_sym_next   = pend_sym_reg;
            m_last_next  = emit.fin;
        end
        if (emit.push && emit_ready) begin
            pend_valid_next = 1'b1;
            pend_sym_next   = emit.sym;
        end else if (emit.fin && emit_ready) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_sym_reg <= pend_sym_next;
        m_sym_reg    <= m_sym_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_sym    = m_sym_reg;
    assign m_last   = m_last_reg;

endmodule

/* hdl/huffman_tree_decoder.sv */
// Huffman tree-walk decoder.
// Input stream: s_tuser selects the transfer kind. A node write (0) loads one
// node table entry. A decode transfer (1) brings a code byte and
// the count of its leading bits to use; bits are walked MSB first, 0 = left,
// 1 = right, and every leaf reached yields its symbol on the output stream.
// m_tlast marks the last symbol produced by one code byte; a byte that ends
// mid-code yields nothing and the walk resumes with the next byte.
// cfg_wr_en/cfg_wr_data set the root index and restart the walk there;
// write it only while the decoder is idle.
// Each tree step is one registered read of the node table, and each leaf
// costs one extra read to fetch the root again. The last symbol of a byte is
// registered for output when the walk ends, earlier ones as soon as the
// following leaf is found. Reset clears the root and cursor to entry 0;
// table contents are undefined until written. If m_tready stays low the walk
// stalls on a leaf once the held-back symbol and the output register are
// both full; s_tready is high again once the byte's last symbol sits in the
// output register, so the next transfer is taken while that symbol waits.
module huffman_tree_decoder
    import hfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [8:0] node_index, [17:9] left_index, [26:18] right_index, [27] is_leaf,
    // [35:28] node_symbol, [43:36] code_byte, [47:44] valid_bits
    input  logic [47:0] s_tdata,
    // [0] op
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] out_symbol
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    node_t            in_node;
    logic [IDX_W-1:0] in_node_index;
    logic [CODE_W-1:0] in_code;
    logic [CNT_W-1:0] in_nbits;
    logic             load;
    logic             bit_msb;
    logic             bits_empty;
    logic             bit_shift;
    hfd_emit_t        emit;
    logic             emit_ready;

    assign in_node_index = s_tdata[8:0];
    assign in_node.left  = s_tdata[17:9];
    assign in_node.right = s_tdata[26:18];
    assign in_node.leaf  = s_tdata[27];
    assign in_node.symbol = s_tdata[35:28];
    assign in_code       = s_tdata[43:36];
    assign in_nbits      = s_tdata[47:44];

    assign load = s_tvalid && s_tready && (s_tuser == OP_DECODE);

    hfd_code_shift u_shift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_byte  (in_code),
        .load_cnt   (in_nbits),
        .shift      (bit_shift),
        .bit_msb    (bit_msb),
        .bits_empty (bits_empty)
    );

    hfd_walk u_walk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tuser),
        .in_nbits_zero (in_nbits == '0),
        .in_node       (in_node),
        .in_node_index (in_node_index),
        .bit_msb       (bit_msb),
        .bits_empty    (bits_empty),
        .bit_shift     (bit_shift),
        .emit          (emit),
        .emit_ready    (emit_ready)
    );

    hfd_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit       (emit),
        .emit_ready (emit_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_sym      (m_tdata),
        .m_last     (m_tlast)
    );

endmodule
